// File: hw/rtl/mbt_pkg.sv
`default_nettype none
// ============================================================================
// mbt_pkg
// shared types and constants of the multibit trie prefix lookup unit
// ============================================================================
package mbt_pkg;

    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 6;
    localparam int PORT_IN_W = 8;
    localparam int FANOUT    = 4;
    localparam int SLOT_W    = 2;
    localparam int LEVEL_W   = 4;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = 4'd15;
    localparam logic [LEN_W-1:0]   MIN_LEN    = 6'd2;
    localparam logic [LEN_W-1:0]   MAX_LEN    = 6'd32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic start;
        logic walk;
        logic load_now;
        logic load_held;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
    } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/mbt_req_if.sv
`default_nettype none
// ============================================================================
// mbt_req_if
// request channel: insert or lookup
// ============================================================================
interface mbt_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] address;
    logic [5:0]  prefix_length;
    logic [7:0]  port_in;

    modport source (
        output valid,
        output operation,
        output address,
        output prefix_length,
        output port_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  address,
        input  prefix_length,
        input  port_in,
        output ready
    );
endinterface
`default_nettype wire

// File: hw/rtl/mbt_rsp_if.sv
`default_nettype none
// ============================================================================
// mbt_rsp_if
// result channel: match flag, port and insert status
// ============================================================================
interface mbt_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] port_out;
    logic       status;

    modport source (
        output valid,
        output found,
        output port_out,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  found,
        input  port_out,
        input  status,
        output ready
    );
endinterface
`default_nettype wire

// File: hw/rtl/mbt_ram.sv
`default_nettype none
// ============================================================================
// mbt_ram
// generic simple dual-port ram, one write and one registered read port
// ============================================================================
module mbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hw/rtl/mbt_ctrl.sv
`default_nettype none
// ============================================================================
// mbt_ctrl
// controller: request accept, trie walk sequencing and result handoff
// ============================================================================
module mbt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire mbt_pkg::stat_t st,
    output mbt_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   out_free;

    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        accept        = in_valid && in_ready;
        out_free      = !out_valid_reg || out_ready;
        cmd.start     = accept;
        cmd.walk      = (state_reg == S_WALK);
        cmd.load_now  = (state_reg == S_WALK) && st.walk_done && out_free;
        cmd.load_held = (state_reg == S_HOLD) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (st.walk_done)
                    begin
                        state_reg <= out_free ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cmd.load_now || cmd.load_held)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_hold_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> out_valid_reg)
        else $error("held result while output register empty");

    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_WALK))
        else $error("accepted request did not start a walk");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/mbt_dpath.sv
`default_nettype none
// ============================================================================
// mbt_dpath
// datapath: node memory, walk registers, node allocator and result registers
// ============================================================================
module mbt_dpath #(
    parameter int NODE_COUNT = 1024,
    parameter int PORT_BITS  = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mbt_pkg::cmd_t cmd,
    output mbt_pkg::stat_t     st,
    input  wire logic          operation,
    input  wire logic [31:0]   address,
    input  wire logic [5:0]    prefix_length,
    input  wire logic [7:0]    port_in,
    output logic               found,
    output logic [7:0]         port_out,
    output logic               status
);

    localparam int NODE_BITS = $clog2(NODE_COUNT);
    localparam int FREE_W    = NODE_BITS + 1;
    localparam int ENTRY_W   = 1 + PORT_BITS + NODE_BITS;
    localparam int ROW_W     = mbt_pkg::FANOUT * ENTRY_W;
    localparam int PORT_LSB  = NODE_BITS;
    localparam int MATCH_BIT = NODE_BITS + PORT_BITS;
    localparam int WIDE_W    = (PORT_BITS > mbt_pkg::PORT_IN_W) ? PORT_BITS
                                                                : mbt_pkg::PORT_IN_W;

    // walk registers
    logic                        op_reg;
    logic [mbt_pkg::ADDR_W-1:0]  addr_reg;
    logic [mbt_pkg::LEVEL_W-1:0] last_reg;
    logic [PORT_BITS-1:0]        port_reg;
    logic [NODE_BITS-1:0]        node_reg;
    logic [mbt_pkg::LEVEL_W-1:0] lvl_reg;
    logic                        fresh_reg;
    logic                        hit_reg;
    logic [PORT_BITS-1:0]        hport_reg;
    logic [FREE_W-1:0]           next_free_reg;
    logic                        root_valid_reg;

    // held and output results
    logic                 held_found_reg;
    logic [PORT_BITS-1:0] held_port_reg;
    logic                 held_status_reg;
    logic                 out_found_reg;
    logic [PORT_BITS-1:0] out_port_reg;
    logic                 out_status_reg;

    logic [mbt_pkg::LEN_W-1:0]   len_sat;
    logic [mbt_pkg::LEN_W:0]     len_up;
    logic [mbt_pkg::LEVEL_W:0]   level_count;
    logic [mbt_pkg::LEVEL_W-1:0] last_next;
    logic [WIDE_W-1:0]           port_in_wide;
    logic [WIDE_W-1:0]           port_out_wide;

    logic [mbt_pkg::ADDR_W-1:0]  addr_shifted;
    logic [mbt_pkg::SLOT_W-1:0]  slot;
    logic [ROW_W-1:0]            rd_data;
    logic [ROW_W-1:0]            cur_row;
    logic [ENTRY_W-1:0]          ent;
    logic                        ent_match;
    logic [PORT_BITS-1:0]        ent_port;
    logic [NODE_BITS-1:0]        ent_child;
    logic                        pool_full;

    logic                 wr_en;
    logic                 wr_go;
    logic [ROW_W-1:0]     wr_data;
    logic [NODE_BITS-1:0] rd_addr;
    logic                 advance;
    logic                 alloc;
    logic                 done;
    logic [NODE_BITS-1:0] node_next;
    logic                 hit_next;
    logic [PORT_BITS-1:0] hport_next;
    logic                 res_found;
    logic [PORT_BITS-1:0] res_port;
    logic                 res_status;

    // request decode
    always_comb
    begin
        if (prefix_length == '0)
        begin
            len_sat = mbt_pkg::MIN_LEN;
        end
        else if (prefix_length > mbt_pkg::MAX_LEN)
        begin
            len_sat = mbt_pkg::MAX_LEN;
        end
        else
        begin
            len_sat = prefix_length;
        end
        len_up       = {1'b0, len_sat} + 7'd1;
        level_count  = len_up[mbt_pkg::LEN_W-1:1];
        last_next    = mbt_pkg::LEVEL_W'(level_count - 5'd1);
        port_in_wide = WIDE_W'(port_in);
    end

    // entry select at the current level
    always_comb
    begin
        addr_shifted = addr_reg << {lvl_reg, 1'b0};
        slot         = addr_shifted[mbt_pkg::ADDR_W-1 -: mbt_pkg::SLOT_W];
        if (fresh_reg || (node_reg == '0 && !root_valid_reg))
        begin
            cur_row = '0;
        end
        else
        begin
            cur_row = rd_data;
        end
        ent       = cur_row[slot*ENTRY_W +: ENTRY_W];
        ent_match = ent[MATCH_BIT];
        ent_port  = ent[PORT_LSB +: PORT_BITS];
        ent_child = ent[NODE_BITS-1:0];
        pool_full = (next_free_reg == FREE_W'(NODE_COUNT));
    end

    // one trie level per cycle
    always_comb
    begin
        wr_en      = 1'b0;
        wr_data    = cur_row;
        advance    = 1'b0;
        alloc      = 1'b0;
        done       = 1'b0;
        hit_next   = hit_reg;
        hport_next = hport_reg;
        res_found  = 1'b0;
        res_port   = '0;
        res_status = mbt_pkg::STATUS_OK;

        if (op_reg == mbt_pkg::OP_LOOKUP)
        begin
            if (ent_match)
            begin
                hit_next   = 1'b1;
                hport_next = ent_port;
            end
            res_found = hit_next;
            res_port  = hport_next;
            if (ent_child == '0 || lvl_reg == mbt_pkg::LAST_LEVEL)
            begin
                done = 1'b1;
            end
            else
            begin
                advance = 1'b1;
            end
        end
        else if (lvl_reg == last_reg)
        begin
            wr_en                                  = 1'b1;
            wr_data[slot*ENTRY_W + MATCH_BIT]      = 1'b1;
            wr_data[slot*ENTRY_W + PORT_LSB +: PORT_BITS] = port_reg;
            done                                   = 1'b1;
        end
        else if (ent_child != '0)
        begin
            advance = 1'b1;
        end
        else if (pool_full)
        begin
            // write back so a freshly linked node gets its empty row
            wr_en      = 1'b1;
            res_status = mbt_pkg::STATUS_FULL;
            done       = 1'b1;
        end
        else
        begin
            wr_en                               = 1'b1;
            wr_data[slot*ENTRY_W +: NODE_BITS]  = next_free_reg[NODE_BITS-1:0];
            alloc                               = 1'b1;
            advance                             = 1'b1;
        end

        node_next    = alloc ? next_free_reg[NODE_BITS-1:0] : ent_child;
        wr_go        = wr_en && cmd.walk;
        rd_addr      = cmd.start ? '0 : node_next;
        st.walk_done = done;
    end

    mbt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_go),
        .wr_addr (node_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg  <= FREE_W'(1);
            root_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.walk && alloc)
            begin
                next_free_reg <= next_free_reg + FREE_W'(1);
            end
            if (wr_go && node_reg == '0)
            begin
                root_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg    <= operation;
            addr_reg  <= address;
            last_reg  <= last_next;
            port_reg  <= port_in_wide[PORT_BITS-1:0];
            node_reg  <= '0;
            lvl_reg   <= '0;
            fresh_reg <= 1'b0;
            hit_reg   <= 1'b0;
            hport_reg <= '0;
        end
        else if (cmd.walk && advance)
        begin
            node_reg  <= node_next;
            lvl_reg   <= lvl_reg + 4'd1;
            fresh_reg <= fresh_reg || alloc;
            hit_reg   <= hit_next;
            hport_reg <= hport_next;
        end

        if (cmd.walk && done)
        begin
            held_found_reg  <= res_found;
            held_port_reg   <= res_port;
            held_status_reg <= res_status;
        end

        if (cmd.load_now)
        begin
            out_found_reg  <= res_found;
            out_port_reg   <= res_port;
            out_status_reg <= res_status;
        end
        else if (cmd.load_held)
        begin
            out_found_reg  <= held_found_reg;
            out_port_reg   <= held_port_reg;
            out_status_reg <= held_status_reg;
        end
    end

    always_comb
    begin
        port_out_wide = WIDE_W'(out_port_reg);
        found         = out_found_reg;
        port_out      = port_out_wide[mbt_pkg::PORT_IN_W-1:0];
        status        = out_status_reg;
    end

`ifndef SYNTHESIS
    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg >= FREE_W'(1)) && (next_free_reg <= FREE_W'(NODE_COUNT)))
        else $error("free node pointer out of range");

    a_fresh_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && fresh_reg) |-> (node_reg != '0))
        else $error("root treated as a fresh node");

    a_step_moves_node: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && advance) |-> (node_next != node_reg))
        else $error("walk step reads the row it writes");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/multibit_trie_prefix_lookup_unit.sv
`default_nettype none
// ============================================================================
// multibit_trie_prefix_lookup_unit
// ipv4 longest prefix match over a stride-2 multibit trie in node memory
// ============================================================================
// One request at a time. After accept the walk steps one trie level per
// cycle, since each level is a dependent read of the node memory: a lookup
// walks 1 to 16 levels, an insert of length L walks ceil(L/2) levels
// (length 0 counts as one level, lengths above 32 as 16), fewer when the
// node pool runs out. The result goes to the output register at the last
// level when the output is free, else it is held until the output frees.
// A new request is taken while a result still waits on the output. Node
// rows are written in full by the insert that takes the node from the free
// pointer, so no clearing pass runs after reset.
module multibit_trie_prefix_lookup_unit #(
    parameter int NODE_COUNT = 1024,
    parameter int PORT_BITS  = 8
) (
    input wire logic   clk,
    input wire logic   rst_n,
    mbt_req_if.sink    req,
    mbt_rsp_if.source  rsp
);

    mbt_pkg::cmd_t  cmd;
    mbt_pkg::stat_t st;
    logic           in_ready;
    logic           out_valid;

    mbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    mbt_dpath #(
        .NODE_COUNT (NODE_COUNT),
        .PORT_BITS  (PORT_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .operation     (req.operation),
        .address       (req.address),
        .prefix_length (req.prefix_length),
        .port_in       (req.port_in),
        .found         (rsp.found),
        .port_out      (rsp.port_out),
        .status        (rsp.status)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule
`default_nettype wire
